>>> design/encoder_speed_distance_meter_top_macros.svh
// Assertion helpers shared by the meter's modules.
`ifndef ENCODER_SPEED_DISTANCE_METER_TOP_MACROS_SVH
`define ENCODER_SPEED_DISTANCE_METER_TOP_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ESDM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ESDM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ESDM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> design/esdm_pkg.sv
package esdm_pkg;

	localparam int HISTORY_DEPTH_DEF = 10;
	localparam int STOP_SAMPLES = 3;

	localparam int DIV_W = 64;
	localparam int SPEED_W = 24;
	localparam int CNT_W = 32;
	localparam int PPR_W = 16;
	localparam int CIRC_W = 22;
	localparam int TP_W = 20;
	localparam int WIN_W = 4;
	localparam int THR_W = 24;
	localparam int PULSE_W = 4;
	localparam int PROD_W = CNT_W + CIRC_W;
	localparam int DEN_W = PPR_W + TP_W;
	localparam int PPRK_W = PPR_W + 10;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PPR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CIRC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THR = 3'd4;

	localparam logic [PPR_W-1:0] PPR_RST = 16'd200;
	localparam logic [CIRC_W-1:0] CIRC_RST = 22'd502655;
	localparam logic [TP_W-1:0] TP_RST = 20'd1000;
	localparam logic [WIN_W-1:0] WIN_RST = 4'd10;
	localparam logic [THR_W-1:0] THR_RST = 24'd10;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_SPD1 = 3'd0;
	localparam logic [OP_W-1:0] OP_SPD2 = 3'd1;
	localparam logic [OP_W-1:0] OP_MEAN = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP = 3'd3;
	localparam logic [OP_W-1:0] OP_REV = 3'd4;
	localparam logic [OP_W-1:0] OP_DIST = 3'd5;

	typedef struct packed {
		logic load;
		logic update;
		logic mul_spd;
		logic scale;
		logic div_go;
		logic div_cap;
		logic [OP_W-1:0] op;
		logic write;
		logic walk_go;
		logic mul_dist;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sample;
		logic div_done;
		logic walk_done;
	} status_t;

endpackage

>>> design/encoder_speed_distance_meter_top.sv
// One item is in work at a time: a new item is taken only when the controller is idle,
// after the result of the last one has been loaded to the output. The divider runs four
// times per tick and twice more on a sample, plus a walk over the history.
// Reset clears all counts, the history and the result valid, and loads register defaults.
module encoder_speed_distance_meter_top #(
	parameter int HISTORY_DEPTH = esdm_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [esdm_pkg::PULSE_W-1:0]    pulses,
	input  logic                            take_sample,
	input  logic                            clear,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [esdm_pkg::SPEED_W-1:0]    speed_mm_s,
	output logic [esdm_pkg::SPEED_W-1:0]    smoothed_mm_s,
	output logic                            stopped,
	output logic [esdm_pkg::CNT_W-1:0]      revolutions,
	output logic [esdm_pkg::CNT_W-1:0]      distance_mm,
	output logic [esdm_pkg::CNT_W-1:0]      pulse_total,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [esdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [esdm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import esdm_pkg::*;

	cmd_t cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	esdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	esdm_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pulses        (pulses),
		.take_sample   (take_sample),
		.clear         (clear),
		.cmd           (cmd),
		.status        (status),
		.speed_mm_s    (speed_mm_s),
		.smoothed_mm_s (smoothed_mm_s),
		.stopped       (stopped),
		.revolutions   (revolutions),
		.distance_mm   (distance_mm),
		.pulse_total   (pulse_total)
	);

endmodule

>>> design/esdm_div.sv
module esdm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [esdm_pkg::DIV_W-1:0] dividend,
	input  logic [esdm_pkg::DIV_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [esdm_pkg::DIV_W-1:0] quotient
);
	import esdm_pkg::*;

	localparam int STEP_W = $clog2(DIV_W);

	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic fits;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		fits = trial >= {1'b0, dvs_q};
		diff = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

endmodule

>>> design/esdm_ctrl.sv
`include "encoder_speed_distance_meter_top_macros.svh"

module esdm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output esdm_pkg::cmd_t    cmd,
	input  esdm_pkg::status_t status
);
	import esdm_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UPD = 4'd1;
	localparam logic [3:0] ST_MULS = 4'd2;
	localparam logic [3:0] ST_SCALE = 4'd3;
	localparam logic [3:0] ST_DIV1 = 4'd4;
	localparam logic [3:0] ST_DIV2 = 4'd5;
	localparam logic [3:0] ST_WRITE = 4'd6;
	localparam logic [3:0] ST_WALK = 4'd7;
	localparam logic [3:0] ST_DIVM = 4'd8;
	localparam logic [3:0] ST_DIVS = 4'd9;
	localparam logic [3:0] ST_MULD = 4'd10;
	localparam logic [3:0] ST_DIVR = 4'd11;
	localparam logic [3:0] ST_DIVD = 4'd12;
	localparam logic [3:0] ST_OUT = 4'd13;

	logic [3:0] state_q;
	logic issued_q;
	logic out_valid_q;
	logic div_state;

	always_comb begin
		cmd = '0;
		div_state = 1'b0;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		unique case (state_q)
			ST_IDLE: ;
			ST_UPD: cmd.update = 1'b1;
			ST_MULS: cmd.mul_spd = 1'b1;
			ST_SCALE: cmd.scale = 1'b1;
			ST_DIV1: begin
				div_state = 1'b1;
				cmd.op = OP_SPD1;
			end
			ST_DIV2: begin
				div_state = 1'b1;
				cmd.op = OP_SPD2;
			end
			ST_WRITE: cmd.write = 1'b1;
			ST_WALK: cmd.walk_go = !issued_q;
			ST_DIVM: begin
				div_state = 1'b1;
				cmd.op = OP_MEAN;
			end
			ST_DIVS: begin
				div_state = 1'b1;
				cmd.op = OP_STOP;
			end
			ST_MULD: cmd.mul_dist = 1'b1;
			ST_DIVR: begin
				div_state = 1'b1;
				cmd.op = OP_REV;
			end
			ST_DIVD: begin
				div_state = 1'b1;
				cmd.op = OP_DIST;
			end
			ST_OUT: cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
		cmd.div_go = div_state && !issued_q;
		cmd.div_cap = div_state && issued_q && status.div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.div_go || cmd.walk_go) begin
				issued_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_UPD;
				ST_UPD: state_q <= status.sample ? ST_MULS : ST_WALK;
				ST_MULS: state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_DIV1;
				ST_DIV1: if (cmd.div_cap) begin
					issued_q <= 1'b0;
					state_q <= ST_DIV2;
				end
				ST_DIV2: if (cmd.div_cap) begin
					issued_q <= 1'b0;
					state_q <= ST_WRITE;
				end
				ST_WRITE: state_q <= ST_WALK;
				ST_WALK: if (issued_q && status.walk_done) begin
					issued_q <= 1'b0;
					state_q <= ST_DIVM;
				end
				ST_DIVM: if (cmd.div_cap) begin
					issued_q <= 1'b0;
					state_q <= ST_DIVS;
				end
				ST_DIVS: if (cmd.div_cap) begin
					issued_q <= 1'b0;
					state_q <= ST_MULD;
				end
				ST_MULD: state_q <= ST_DIVR;
				ST_DIVR: if (cmd.div_cap) begin
					issued_q <= 1'b0;
					state_q <= ST_DIVD;
				end
				ST_DIVD: if (cmd.div_cap) begin
					issued_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_OUT: if (cmd.out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	`ESDM_ASSERT(a_accept_starts_update, clk, arst_n, (in_valid && in_ready) |=> (state_q == ST_UPD), "accepted item did not start the update")

endmodule

>>> design/esdm_dp.sv
`include "encoder_speed_distance_meter_top_macros.svh"

module esdm_dp #(
	parameter int HISTORY_DEPTH = esdm_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [esdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [esdm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [esdm_pkg::PULSE_W-1:0]    pulses,
	input  logic                            take_sample,
	input  logic                            clear,
	input  esdm_pkg::cmd_t                  cmd,
	output esdm_pkg::status_t               status,
	output logic [esdm_pkg::SPEED_W-1:0]    speed_mm_s,
	output logic [esdm_pkg::SPEED_W-1:0]    smoothed_mm_s,
	output logic                            stopped,
	output logic [esdm_pkg::CNT_W-1:0]      revolutions,
	output logic [esdm_pkg::CNT_W-1:0]      distance_mm,
	output logic [esdm_pkg::CNT_W-1:0]      pulse_total
);
	import esdm_pkg::*;

	localparam int POS_W = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = SPEED_W + CW;
	localparam int LW = (CW > WIN_W) ? CW : WIN_W;
	localparam int S3_W = SPEED_W + 2;

	logic [PPR_W-1:0] ppr_q;
	logic [CIRC_W-1:0] circ_q;
	logic [TP_W-1:0] tp_q;
	logic [WIN_W-1:0] win_q;
	logic [THR_W-1:0] thr_q;

	logic [PULSE_W-1:0] pulses_q;
	logic sample_q;
	logic clear_q;

	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] ref_q;
	logic [CNT_W-1:0] ticks_q;
	logic [SPEED_W-1:0] last_q;
	logic [POS_W-1:0] pos_q;
	logic [HISTORY_DEPTH-1:0] hvalid_q;
	logic [SPEED_W-1:0] hist_mem [HISTORY_DEPTH];

	logic [PROD_W-1:0] prod_q;
	logic [DIV_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DIV_W-1:0] q1_q;
	logic [SPEED_W-1:0] spd_calc_q;
	logic [SPEED_W-1:0] mean_q;
	logic stop_q;
	logic [CNT_W-1:0] rev_q;
	logic [CNT_W-1:0] dist_q;

	logic walking_q;
	logic [POS_W-1:0] ridx_q;
	logic [LW-1:0] wi_q;
	logic [SPEED_W-1:0] rd_s1;
	logic hv_s1;
	logic v_s1;
	logic last_s1;
	logic [LW-1:0] i_s1;
	logic [SUM_W-1:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic [S3_W-1:0] sum3_q;
	logic [1:0] cnt3_q;

	logic [LW-1:0] wlim;
	logic [LW-1:0] nwalk;
	logic [SPEED_W-1:0] ent;
	logic [SPEED_W-1:0] spd_final;
	logic [PPRK_W-1:0] ppr_x;
	logic [PPRK_W-1:0] ppr_k;
	logic [DIV_W-1:0] prod_x;
	logic [DIV_W-1:0] div_a;
	logic [DIV_W-1:0] div_b;
	logic div_busy;
	logic div_done;
	logic [DIV_W-1:0] div_q;

	always_comb begin
		wlim = (LW'(win_q) > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH) : LW'(win_q);
		nwalk = (wlim < LW'(STOP_SAMPLES)) ? LW'(STOP_SAMPLES) : wlim;
		ent = hv_s1 ? rd_s1 : '0;
		spd_final = (ppr_q == '0 || tp_q == '0 || ticks_q == '0) ? '0 : spd_calc_q;
		ppr_x = PPRK_W'(ppr_q);
		ppr_k = (ppr_x << 10) - (ppr_x << 4) - (ppr_x << 3);
		prod_x = DIV_W'(prod_q);
		case (cmd.op)
			OP_SPD1: begin
				div_a = num_q;
				div_b = DIV_W'(den_q);
			end
			OP_SPD2: begin
				div_a = q1_q;
				div_b = DIV_W'(ticks_q);
			end
			OP_MEAN: begin
				div_a = DIV_W'(sum_q);
				div_b = DIV_W'(cnt_q);
			end
			OP_STOP: begin
				div_a = DIV_W'(sum3_q);
				div_b = DIV_W'(cnt3_q);
			end
			OP_REV: begin
				div_a = DIV_W'(total_q);
				div_b = DIV_W'(ppr_q);
			end
			OP_DIST: begin
				div_a = prod_x;
				div_b = DIV_W'(ppr_k);
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	esdm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q <= PPR_RST;
			circ_q <= CIRC_RST;
			tp_q <= TP_RST;
			win_q <= WIN_RST;
			thr_q <= THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PPR: ppr_q <= cfg_data[PPR_W-1:0];
				REG_CIRC: circ_q <= cfg_data[CIRC_W-1:0];
				REG_TP: tp_q <= cfg_data[TP_W-1:0];
				REG_WIN: win_q <= cfg_data[WIN_W-1:0];
				REG_THR: thr_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= 1'b0;
			total_q <= '0;
			ref_q <= '0;
			ticks_q <= '0;
			last_q <= '0;
			pos_q <= '0;
			hvalid_q <= '0;
			walking_q <= 1'b0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			cnt_q <= '0;
			cnt3_q <= '0;
		end else begin
			if (cmd.load) begin
				sample_q <= take_sample;
			end
			if (cmd.update) begin
				if (clear_q) begin
					total_q <= CNT_W'(pulses_q);
					ref_q <= '0;
					ticks_q <= CNT_W'(1);
					last_q <= '0;
					pos_q <= '0;
					hvalid_q <= '0;
				end else begin
					total_q <= total_q + CNT_W'(pulses_q);
					if (ticks_q != '1) begin
						ticks_q <= ticks_q + 1'b1;
					end
				end
			end
			if (cmd.write) begin
				last_q <= spd_final;
				ref_q <= total_q;
				ticks_q <= '0;
				hvalid_q[pos_q] <= 1'b1;
				pos_q <= (pos_q == POS_W'(HISTORY_DEPTH - 1)) ? '0 : pos_q + 1'b1;
			end
			if (cmd.walk_go) begin
				walking_q <= 1'b1;
				cnt_q <= '0;
				cnt3_q <= '0;
			end else if (walking_q && wi_q == nwalk - 1'b1) begin
				walking_q <= 1'b0;
			end
			v_s1 <= walking_q;
			last_s1 <= walking_q && (wi_q == nwalk - 1'b1);
			if (v_s1 && ent != '0) begin
				if (i_s1 < wlim) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (i_s1 < LW'(STOP_SAMPLES)) begin
					cnt3_q <= cnt3_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pulses_q <= pulses;
			clear_q <= clear;
		end
		if (cmd.write) begin
			hist_mem[pos_q] <= spd_final;
		end
		rd_s1 <= hist_mem[ridx_q];
		hv_s1 <= hvalid_q[ridx_q];
		i_s1 <= wi_q;
		if (cmd.walk_go) begin
			ridx_q <= (pos_q == '0) ? POS_W'(HISTORY_DEPTH - 1) : pos_q - 1'b1;
			wi_q <= '0;
			sum_q <= '0;
			sum3_q <= '0;
		end else begin
			if (walking_q) begin
				ridx_q <= (ridx_q == '0) ? POS_W'(HISTORY_DEPTH - 1) : ridx_q - 1'b1;
				wi_q <= wi_q + 1'b1;
			end
			if (v_s1 && ent != '0) begin
				if (i_s1 < wlim) begin
					sum_q <= sum_q + SUM_W'(ent);
				end
				if (i_s1 < LW'(STOP_SAMPLES)) begin
					sum3_q <= sum3_q + S3_W'(ent);
				end
			end
		end
		if (cmd.mul_spd) begin
			prod_q <= PROD_W'(total_q - ref_q) * PROD_W'(circ_q);
			den_q <= DEN_W'(ppr_q) * DEN_W'(tp_q);
		end
		if (cmd.scale) begin
			num_q <= (prod_x << 10) - (prod_x << 4) - (prod_x << 3);
		end
		if (cmd.mul_dist) begin
			prod_q <= PROD_W'(total_q) * PROD_W'(circ_q);
		end
		if (cmd.div_cap) begin
			case (cmd.op)
				OP_SPD1: q1_q <= div_q;
				OP_SPD2: spd_calc_q <= (div_q[DIV_W-1:SPEED_W] != '0) ? '1 : div_q[SPEED_W-1:0];
				OP_MEAN: mean_q <= (cnt_q == '0) ? '0 : div_q[SPEED_W-1:0];
				OP_STOP: stop_q <= ((cnt3_q == '0) ? '0 : div_q[SPEED_W-1:0]) < thr_q;
				OP_REV: rev_q <= (ppr_q == '0) ? '0 : div_q[CNT_W-1:0];
				OP_DIST: begin
					if (ppr_q == '0) begin
						dist_q <= '0;
					end else begin
						dist_q <= (div_q[DIV_W-1:CNT_W] != '0) ? '1 : div_q[CNT_W-1:0];
					end
				end
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			speed_mm_s <= last_q;
			smoothed_mm_s <= mean_q;
			stopped <= stop_q;
			revolutions <= rev_q;
			distance_mm <= dist_q;
			pulse_total <= total_q;
		end
	end

	always_comb begin
		status.sample = sample_q;
		status.div_done = div_done;
		status.walk_done = v_s1 && last_s1;
	end

	`ESDM_ASSERT(a_div_go_idle, clk, arst_n, cmd.div_go |-> !div_busy, "divider started while busy")
	`ESDM_ASSERT_NEVER(a_pos_range, clk, arst_n, pos_q > POS_W'(HISTORY_DEPTH - 1), "history position out of range")
	`ESDM_ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(HISTORY_DEPTH), "window count exceeds history depth")

endmodule

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import esdm_pkg::*;

	localparam int DEPTH = HISTORY_DEPTH_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;
	localparam int SETTLE_CYCLES = 500;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [SPEED_W-1:0] smoothed;
		logic stopped;
		logic [CNT_W-1:0] revs;
		logic [CNT_W-1:0] distance;
		logic [CNT_W-1:0] total;
	} meter_out_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [PULSE_W-1:0] pulses;
	logic take_sample;
	logic clear;
	logic out_valid;
	logic out_ready;
	logic [SPEED_W-1:0] speed_mm_s;
	logic [SPEED_W-1:0] smoothed_mm_s;
	logic stopped;
	logic [CNT_W-1:0] revolutions;
	logic [CNT_W-1:0] distance_mm;
	logic [CNT_W-1:0] pulse_total;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Mirror of the meter's registers and counters.
	logic [PPR_W-1:0] m_ppr;
	logic [CIRC_W-1:0] m_circ;
	logic [TP_W-1:0] m_tick_us;
	logic [WIN_W-1:0] m_window;
	logic [THR_W-1:0] m_thresh;
	logic [CNT_W-1:0] m_total;
	logic [CNT_W-1:0] m_ref;
	logic [CNT_W-1:0] m_ticks;
	logic [SPEED_W-1:0] m_hist [DEPTH];
	int m_pos;
	logic [SPEED_W-1:0] m_last;

	meter_out_t expected_q [$];
	int errors;
	bit quiet;
	int hold_cycles;

	encoder_speed_distance_meter_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pulses(pulses), .take_sample(take_sample), .clear(clear),
		.out_valid(out_valid), .out_ready(out_ready),
		.speed_mm_s(speed_mm_s), .smoothed_mm_s(smoothed_mm_s), .stopped(stopped),
		.revolutions(revolutions), .distance_mm(distance_mm), .pulse_total(pulse_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic void clear_counts();
		m_total = '0;
		m_ref = '0;
		m_ticks = '0;
		for (int i = 0; i < DEPTH; i++)
			m_hist[i] = '0;
		m_pos = 0;
		m_last = '0;
	endfunction

	function automatic void load_defaults();
		m_ppr = PPR_RST;
		m_circ = CIRC_RST;
		m_tick_us = TP_RST;
		m_window = WIN_RST;
		m_thresh = THR_RST;
		clear_counts();
	endfunction

	function automatic logic [SPEED_W-1:0] speed_of(input logic [CNT_W-1:0] delta,
			input logic [CNT_W-1:0] ticks);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		if (m_ppr == 0 || ticks == 0 || m_tick_us == 0)
			return '0;
		num = 64'(delta) * 64'(m_circ) * 64'd1000;
		den = 64'(m_ppr) * 64'(m_tick_us);
		q = (num / den) / 64'(ticks);
		return (q > 64'hFFFFFF) ? 24'hFFFFFF : q[SPEED_W-1:0];
	endfunction

	function automatic logic [SPEED_W-1:0] positive_mean(input int window);
		logic [31:0] sum;
		int cnt;
		int idx;
		sum = 0;
		cnt = 0;
		idx = m_pos;
		if (window > DEPTH)
			window = DEPTH;
		for (int i = 0; i < window; i++) begin
			idx = (idx == 0) ? DEPTH - 1 : idx - 1;
			if (m_hist[idx] > 0) begin
				sum += m_hist[idx];
				cnt++;
			end
		end
		return cnt ? SPEED_W'(sum / cnt) : '0;
	endfunction

	function automatic meter_out_t meter_tick(input logic [PULSE_W-1:0] p, input logic smp,
			input logic clr);
		meter_out_t r;
		logic [63:0] d;
		if (clr)
			clear_counts();
		m_total = m_total + p;
		if (m_ticks != 32'hFFFFFFFF)
			m_ticks++;
		if (smp) begin
			m_last = speed_of(m_total - m_ref, m_ticks);
			m_ref = m_total;
			m_ticks = '0;
			m_hist[m_pos] = m_last;
			m_pos = (m_pos + 1) % DEPTH;
		end
		r.speed = m_last;
		r.smoothed = positive_mean(m_window);
		r.stopped = positive_mean(STOP_SAMPLES) < m_thresh;
		if (m_ppr == 0) begin
			r.revs = '0;
			r.distance = '0;
		end else begin
			r.revs = m_total / m_ppr;
			d = (64'(m_total) * 64'(m_circ)) / (64'(m_ppr) * 64'd1000);
			r.distance = (d > 64'hFFFFFFFF) ? 32'hFFFFFFFF : d[31:0];
		end
		r.total = m_total;
		return r;
	endfunction

	task automatic send_tick(input logic [PULSE_W-1:0] p, input logic smp, input logic clr);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pulses = p;
		take_sample = smp;
		clear = clr;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(meter_tick(p, smp, clr));
	endtask

	task automatic send_random(input int n, input int sample_odds);
		for (int i = 0; i < n; i++)
			send_tick(PULSE_W'($urandom), $urandom_range(0, sample_odds - 1) == 0,
				$urandom_range(0, 60) == 0);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PPR: m_ppr = data[PPR_W-1:0];
			REG_CIRC: m_circ = data[CIRC_W-1:0];
			REG_TP: m_tick_us = data[TP_W-1:0];
			REG_WIN: m_window = data[WIN_W-1:0];
			REG_THR: m_thresh = data[THR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver: random stall bursts, plus long holds requested by the tests.
	initial begin
		int stall_left;
		meter_out_t want;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 16);
			end
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected item", pulse_total, 0);
				end else begin
					want = expected_q.pop_front();
					if (speed_mm_s !== want.speed) report("speed_mm_s", speed_mm_s, want.speed);
					if (smoothed_mm_s !== want.smoothed)
						report("smoothed_mm_s", smoothed_mm_s, want.smoothed);
					if (stopped !== want.stopped) report("stopped", stopped, want.stopped);
					if (revolutions !== want.revs) report("revolutions", revolutions, want.revs);
					if (distance_mm !== want.distance)
						report("distance_mm", distance_mm, want.distance);
					if (pulse_total !== want.total) report("pulse_total", pulse_total, want.total);
				end
			end
		end
	end

	task automatic test_defaults();
		send_tick(4'd0, 1'b1, 1'b0);
		send_tick(4'd15, 1'b0, 1'b0);
		send_tick(4'd15, 1'b1, 1'b0);
		send_tick(4'd7, 1'b0, 1'b0);
		send_tick(4'd8, 1'b0, 1'b0);
		send_tick(4'd1, 1'b1, 1'b0);
		send_tick(4'd9, 1'b1, 1'b1);
		send_tick(4'd15, 1'b0, 1'b1);
		send_tick(4'd0, 1'b0, 1'b0);
		send_tick(4'd0, 1'b1, 1'b0);
		for (int i = 0; i < 12; i++)
			send_tick(4'd15 - 4'(i), 1'b1, 1'b0);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_PPR, 24'd0);
		send_random(6, 2);
		write_reg(REG_PPR, 24'hFFFFFF);
		write_reg(REG_TP, 24'd0);
		send_random(6, 2);
		write_reg(REG_PPR, 24'd1);
		write_reg(REG_TP, 24'd1);
		write_reg(REG_CIRC, 24'hFFFFFF);
		write_reg(REG_WIN, 24'd0);
		write_reg(REG_THR, 24'hFFFFFF);
		send_random(12, 2);
		write_reg(REG_TP, 24'hFFFFFF);
		write_reg(REG_CIRC, 24'd1);
		write_reg(REG_WIN, 24'd15);
		write_reg(REG_THR, 24'd0);
		send_random(20, 3);
		for (logic [CFG_IDX_W-1:0] k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++) begin
			write_reg(k, CFG_DATA_W'($urandom));
			if (k == REG_SPARE_LAST)
				break;
		end
		send_random(8, 2);
		wait_idle();
	endtask

	task automatic test_full_backpressure();
		hold_cycles = 3000;
		send_random(40, 3);
		wait_idle();
	endtask

	task automatic test_drain_pause();
		send_random(20, 3);
		wait_idle();
		send_random(20, 3);
		wait_idle();
	endtask

	task automatic randomize_registers();
		logic [CFG_DATA_W-1:0] v;
		for (int r = REG_PPR; r <= REG_THR; r++) begin
			case ($urandom_range(0, 5))
				0: v = '0;
				1: v = '1;
				2: v = 24'(1);
				3: v = CFG_DATA_W'($urandom_range(1, 400));
				default: v = CFG_DATA_W'($urandom);
			endcase
			write_reg(CFG_IDX_W'(r), v);
		end
		if ($urandom_range(0, 2) != 0)
			write_reg(REG_THR, CFG_DATA_W'($urandom_range(0, 3000)));
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 12; ph++) begin
			randomize_registers();
			send_random(100, $urandom_range(1, 6));
			wait_idle();
		end
		load_defaults();
		write_reg(REG_PPR, PPR_RST);
		write_reg(REG_CIRC, CIRC_RST);
		write_reg(REG_TP, TP_RST);
		write_reg(REG_WIN, WIN_RST);
		write_reg(REG_THR, THR_RST);
		send_tick(4'd0, 1'b0, 1'b1);
		quiet = 1'b1;
		send_random(150, 4);
		wait_idle();
	endtask

	initial begin
		errors = 0;
		quiet = 1'b0;
		hold_cycles = 0;
		in_valid = 1'b0;
		pulses = '0;
		take_sample = 1'b0;
		clear = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PPR;
		cfg_data = '0;
		load_defaults();
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		test_defaults();
		test_register_extremes();
		test_full_backpressure();
		test_drain_pause();
		test_random_phases();

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/esdm_pkg.sv
design/esdm_div.sv
design/esdm_ctrl.sv
design/esdm_dp.sv
design/encoder_speed_distance_meter_top.sv
bench/tb_top.sv
